/* sv/ffha_pkg.sv */
// Package for the first-fit heap allocator: constants, status codes, types.
// No dependencies.
package ffha_pkg;
  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 16;
  localparam int PAGE_BYTES   = 4096;
  localparam int WORD_ALIGN   = 4;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
  localparam int PAGE_SH      = $clog2(PAGE_BYTES);
  localparam int ALIGN_SH     = $clog2(WORD_ALIGN);
  localparam logic [32:0] ADDR_LIMIT = 33'h0_FFC0_0000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO      = 3'd1;
  localparam logic [2:0] ST_NOMEM     = 3'd2;
  localparam logic [2:0] ST_NULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic [1:0] REG_HEAP_BASE  = 2'd0;
  localparam logic [1:0] REG_INIT_PAGES = 2'd1;
  localparam logic [1:0] REG_SPLIT_MIN  = 2'd2;
  localparam logic [1:0] REG_MAX_PAGES  = 2'd3;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        used;
  } entry_t;
endpackage

/* sv/ffha_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on nothing.
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] req_size;
  logic [31:0] address;
  modport source (output valid, op, req_size, address, input ready);
  modport sink (input valid, op, req_size, address, output ready);
endinterface

interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_address;
  logic [2:0]  status;
  modport source (output valid, result_address, status, input ready);
  modport sink (input valid, result_address, status, output ready);
endinterface

/* sv/ffha_ram.sv */
// Block table memory: one write port, one registered read port.
// Depends on ffha_pkg.
module ffha_ram
  import ffha_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);
  entry_t mem [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/first_fit_heap_allocator.sv */
// First-fit heap allocator top level: APB registers, sequencer, block table.
// Depends on ffha_pkg, ffha_if and ffha_ram.
//
//  channel | direction | handshake      | payload
//  req     | in        | valid/ready    | op, req_size, address
//  rsp     | out       | valid/ready    | result_address, status
//  apb     | in        | psel/penable   | 4-bit paddr, 32-bit pwdata/prdata
//
// After the accepting edge the sequencer passes S_DISP, then S_RD and S_CHK for each
// table entry scanned; a split moves entries through S_SHR and S_SHW and ends in S_FIN,
// and a merge writes in S_FNEXT and then moves entries the same way, before S_OUT.
// The single table memory port with its registered read sets this order. The result
// waits in an output register; a new request is taken only once it has been handed on.
// Reset clears the sequencer, the block count, the page count and the build flag.
module first_fit_heap_allocator
  import ffha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ffha_req_if.sink    req,
  ffha_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_FNEXT = 4'd4;
  localparam logic [3:0] S_SHR   = 4'd5;
  localparam logic [3:0] S_SHW   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [31:0] heap_base;
  logic [15:0] initial_pages;
  logic [15:0] split_min_size;
  logic [19:0] max_pages;

  logic [CNT_W-1:0] block_count;
  logic [19:0]      pages_in_use;
  logic             heap_ready;

  logic [3:0]       state;
  logic             op;
  logic [32:0]      s_len;       // rounded request size
  logic [31:0]      faddr;
  logic [IDX_W:0]   idx;
  logic [IDX_W:0]   mv;          // shift cursor
  logic             shift_up;    // 1: insert (move up), 0: remove (move down)
  logic [1:0]       gap;         // entries removed by a merge
  entry_t           ins;         // entry placed after an insert shift
  logic [IDX_W:0]   ins_pos;
  entry_t           cur;         // entry being freed
  entry_t           prev;        // entry scanned just before cur
  logic             rsp_valid;
  logic [31:0]      rsp_addr;
  logic [2:0]       rsp_status;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata, rdata;

  ffha_ram u_ram (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
                  .raddr(raddr), .rdata(rdata));

  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_HEAP_BASE:  prdata = heap_base;
      REG_INIT_PAGES: prdata = {16'd0, initial_pages};
      REG_SPLIT_MIN:  prdata = {16'd0, split_min_size};
      REG_MAX_PAGES:  prdata = {12'd0, max_pages};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base      <= 32'd0;
      initial_pages  <= 16'd16;
      split_min_size <= 16'd16;
      max_pages      <= 20'd1024;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_HEAP_BASE:  heap_base <= pwdata;
        REG_INIT_PAGES: initial_pages <= pwdata[15:0];
        REG_SPLIT_MIN:  split_min_size <= pwdata[15:0];
        REG_MAX_PAGES:  max_pages <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  assign req.ready          = (state == S_IDLE) && !rsp_valid;
  assign rsp.valid          = rsp_valid;
  assign rsp.result_address = rsp_addr;
  assign rsp.status         = rsp_status;

  // Build-time arithmetic.
  logic [32:0] build_bytes, build_end;
  assign build_bytes = {5'd0, initial_pages, {PAGE_SH{1'b0}}};
  assign build_end   = {1'b0, heap_base} + build_bytes;
  logic build_ok;
  assign build_ok = (build_end < ADDR_LIMIT) && (initial_pages != 16'd0) &&
                    ({4'd0, initial_pages} <= max_pages);
  entry_t build_e;
  always_comb begin
    build_e.start = heap_base;
    build_e.size  = build_bytes[31:0] - 32'(HEADER_BYTES);
    build_e.used  = 1'b0;
  end

  // Fit check on the entry just read.
  logic [32:0] diff, rest;
  assign diff = {1'b0, rdata.size} - s_len;
  assign rest = diff - 33'(HEADER_BYTES);
  logic fits, can_split;
  assign fits = !rdata.used && ({1'b0, rdata.size} >= s_len);
  assign can_split = (diff >= 33'(HEADER_BYTES)) && (block_count < CNT_W'(MAX_BLOCKS)) &&
                     (rest >= {17'd0, split_min_size});

  logic [IDX_W:0] idx_inc;
  logic           last_entry;
  assign idx_inc    = idx + 1'b1;
  assign last_entry = (idx_inc == block_count);

  entry_t alloc_e;
  always_comb begin
    alloc_e.start = rdata.start;
    alloc_e.size  = can_split ? s_len[31:0] : rdata.size;
    alloc_e.used  = 1'b1;
  end

  // Grow arithmetic on the last entry.
  logic [33:0] need, region, grow_bytes, grow_end;
  logic [21:0] npages;
  assign need       = {1'b0, s_len} + 34'(HEADER_BYTES + PAGE_BYTES - 1);
  assign npages     = 22'(need >> PAGE_SH);
  assign region     = {2'd0, rdata.start} + 34'(HEADER_BYTES) + {2'd0, rdata.size};
  assign grow_bytes = {npages, {PAGE_SH{1'b0}}};
  assign grow_end   = region + grow_bytes;
  logic grow_ok;
  assign grow_ok = (grow_end < {1'b0, ADDR_LIMIT}) &&
                   ({2'd0, pages_in_use} + npages <= {2'd0, max_pages}) &&
                   (block_count < CNT_W'(MAX_BLOCKS));
  entry_t grow_e;
  always_comb begin
    grow_e.start = region[31:0];
    grow_e.size  = grow_bytes[31:0] - 32'(HEADER_BYTES);
    grow_e.used  = 1'b1;
  end

  // Free: match on the payload address, then merge with free neighbors.
  logic addr_match;
  assign addr_match = ({2'd0, rdata.start} + 34'(HEADER_BYTES)) == {2'd0, faddr};
  logic merge_prev, merge_next;
  assign merge_prev = (idx != '0) && !prev.used;
  assign merge_next = (idx_inc < block_count) && !rdata.used;
  logic [IDX_W:0] merge_pos;
  logic [1:0]     merge_gap;
  assign merge_pos = merge_prev ? idx - 1'b1 : idx;
  assign merge_gap = {1'b0, merge_prev} + {1'b0, merge_next};
  entry_t merged_e;
  always_comb begin
    merged_e.start = merge_prev ? prev.start : cur.start;
    merged_e.size  = cur.size +
                     (merge_prev ? prev.size + 32'(HEADER_BYTES) : 32'd0) +
                     (merge_next ? rdata.size + 32'(HEADER_BYTES) : 32'd0);
    merged_e.used  = 1'b0;
  end

  logic [IDX_W:0] mv_src;
  assign mv_src = mv + {{(IDX_W-1){1'b0}}, gap};

  // Memory port control.
  always_comb begin
    we    = 1'b0;
    waddr = idx[IDX_W-1:0];
    wdata = rdata;
    raddr = idx[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (req.valid && req.ready && !heap_ready && build_ok) begin
          we    = 1'b1;
          waddr = '0;
          wdata = build_e;
        end
      end
      S_CHK: begin
        raddr = idx_inc[IDX_W-1:0];
        if (op == OP_ALLOC) begin
          if (fits) begin
            we    = 1'b1;
            wdata = alloc_e;
          end else if (last_entry && grow_ok) begin
            we    = 1'b1;
            waddr = block_count[IDX_W-1:0];
            wdata = grow_e;
          end
        end
      end
      S_FNEXT: begin
        we    = 1'b1;
        waddr = merge_pos[IDX_W-1:0];
        wdata = merged_e;
      end
      S_SHR: raddr = shift_up ? IDX_W'(mv - 1'b1) : mv_src[IDX_W-1:0];
      S_SHW: begin
        we    = 1'b1;
        waddr = mv[IDX_W-1:0];
      end
      S_FIN: begin
        we    = 1'b1;
        waddr = ins_pos[IDX_W-1:0];
        wdata = ins;
      end
      default: ;
    endcase
  end

  entry_t nxt_split;
  always_comb begin
    nxt_split.start = rdata.start + 32'(HEADER_BYTES) + s_len[31:0];
    nxt_split.size  = rest[31:0];
    nxt_split.used  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rsp_valid    <= 1'b0;
      rsp_addr     <= 32'd0;
      rsp_status   <= ST_OK;
      block_count  <= '0;
      pages_in_use <= '0;
      heap_ready   <= 1'b0;
    end else begin
      if (state == S_OUT) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (req.valid && req.ready) begin
          op         <= req.op;
          s_len      <= ({1'b0, req.req_size} + 33'(WORD_ALIGN - 1)) >> ALIGN_SH << ALIGN_SH;
          faddr      <= req.address;
          idx        <= '0;
          rsp_addr   <= 32'd0;
          rsp_status <= ST_OK;
          state      <= S_DISP;
          if (!heap_ready) begin
            heap_ready <= 1'b1;
            if (build_ok) begin
              block_count  <= CNT_W'(1);
              pages_in_use <= {4'd0, initial_pages};
            end
          end
        end
        S_DISP: begin
          if (op == OP_ALLOC) begin
            if (s_len == 33'd0) begin
              rsp_status <= ST_ZERO;
              state      <= S_OUT;
            end else if (block_count == '0) begin
              rsp_status <= ST_NOMEM;
              state      <= S_OUT;
            end else begin
              state <= S_RD;
            end
          end else begin
            if (faddr == 32'd0) begin
              rsp_status <= ST_NULL;
              state      <= S_OUT;
            end else if (block_count == '0) begin
              rsp_status <= ST_NOT_FOUND;
              state      <= S_OUT;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (op == OP_ALLOC) begin
            if (fits) begin
              rsp_addr <= rdata.start + 32'(HEADER_BYTES);
              if (can_split) begin
                ins      <= nxt_split;
                ins_pos  <= idx_inc;
                mv       <= (IDX_W+1)'(block_count);
                shift_up <= 1'b1;
                state    <= S_SHR;
              end else begin
                state <= S_OUT;
              end
            end else if (last_entry) begin
              // Nothing fits: grow the heap at its end, or fail.
              if (grow_ok) begin
                block_count  <= block_count + 1'b1;
                pages_in_use <= pages_in_use + npages[19:0];
                rsp_addr     <= region[31:0] + 32'(HEADER_BYTES);
              end else begin
                rsp_status <= ST_NOMEM;
              end
              state <= S_OUT;
            end else begin
              idx   <= idx_inc;
              state <= S_RD;
            end
          end else begin
            if (addr_match) begin
              cur   <= rdata;
              state <= S_FNEXT;
            end else if (last_entry) begin
              rsp_status <= ST_NOT_FOUND;
              state      <= S_OUT;
            end else begin
              prev  <= rdata;
              idx   <= idx_inc;
              state <= S_RD;
            end
          end
        end
        S_FNEXT: begin
          if (merge_gap == 2'd0) begin
            state <= S_OUT;
          end else begin
            mv       <= merge_pos + 1'b1;
            gap      <= merge_gap;
            shift_up <= 1'b0;
            state    <= S_SHR;
          end
        end
        S_SHR: begin
          if (shift_up) begin
            if (mv > ins_pos) begin
              state <= S_SHW;
            end else begin
              state <= S_FIN;
            end
          end else begin
            if (mv_src < block_count) begin
              state <= S_SHW;
            end else begin
              block_count <= block_count - CNT_W'(gap);
              state       <= S_OUT;
            end
          end
        end
        S_SHW: begin
          mv    <= shift_up ? mv - 1'b1 : mv + 1'b1;
          state <= S_SHR;
        end
        S_FIN: begin
          block_count <= block_count + 1'b1;
          state       <= S_OUT;
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* sim/first_fit_heap_allocator_tb.sv */
// Testbench for first_fit_heap_allocator: drives alloc/free requests and APB writes, and
// checks each result against a block-table predictor kept in the bench.
// Depends on ffha_pkg, ffha_if and the allocator RTL.
module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  typedef struct {
    logic [31:0] result_address;
    logic [2:0]  status;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ffha_req_if req ();
  ffha_rsp_if rsp ();

  first_fit_heap_allocator dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Predicted heap state and register copies.
  logic [31:0] hp_start [MAX_BLOCKS];
  logic [31:0] hp_size [MAX_BLOCKS];
  bit          hp_used [MAX_BLOCKS];
  int          hp_count;
  longint      hp_pages;
  bit          hp_built;
  logic [31:0] cfg_base = 32'd0;
  logic [15:0] cfg_init_pages = 16'd16;
  logic [15:0] cfg_split_min = 16'd16;
  logic [19:0] cfg_max_pages = 20'd1024;

  alloc_result_t pending_results[$];
  int  errors = 0;
  bit  no_idle = 1'b0;
  bit  long_hold = 1'b0;

  initial begin
    req.valid = 1'b0;
    req.op = OP_ALLOC;
    req.req_size = '0;
    req.address = '0;
    rsp.ready = 1'b0;
  end

  task automatic table_insert(int pos, logic [31:0] start, logic [31:0] size, bit used);
    for (int k = hp_count; k > pos; k--) begin
      hp_start[k] = hp_start[k-1];
      hp_size[k] = hp_size[k-1];
      hp_used[k] = hp_used[k-1];
    end
    hp_start[pos] = start;
    hp_size[pos] = size;
    hp_used[pos] = used;
    hp_count++;
  endtask

  task automatic table_remove(int pos);
    for (int k = pos; k + 1 < hp_count; k++) begin
      hp_start[k] = hp_start[k+1];
      hp_size[k] = hp_size[k+1];
      hp_used[k] = hp_used[k+1];
    end
    hp_count--;
  endtask

  task automatic predict_alloc(logic [31:0] size, output alloc_result_t r);
    longint unsigned s, sz, rest, n, region, fin;
    int last;
    r.result_address = '0;
    r.status = ST_OK;
    if (size == 0) begin
      r.status = ST_ZERO;
      return;
    end
    s = (longint'(size) + WORD_ALIGN - 1) / WORD_ALIGN * WORD_ALIGN;
    for (int i = 0; i < hp_count; i++) begin
      if (!hp_used[i] && longint'(hp_size[i]) >= s) begin
        sz = hp_size[i];
        if (sz - s >= HEADER_BYTES && hp_count < MAX_BLOCKS) begin
          rest = sz - s - HEADER_BYTES;
          if (rest >= cfg_split_min) begin
            table_insert(i + 1, 32'(hp_start[i] + HEADER_BYTES + s), 32'(rest), 1'b0);
            hp_size[i] = 32'(s);
          end
        end
        hp_used[i] = 1'b1;
        r.result_address = hp_start[i] + HEADER_BYTES;
        return;
      end
    end
    r.status = ST_NOMEM;
    if (hp_count == 0 || hp_count >= MAX_BLOCKS) return;
    n = (s + HEADER_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
    last = hp_count - 1;
    region = longint'(hp_start[last]) + HEADER_BYTES + hp_size[last];
    fin = region + n * PAGE_BYTES;
    if (fin >= ADDR_LIMIT || hp_pages + n > cfg_max_pages) return;
    table_insert(hp_count, 32'(region), 32'(n * PAGE_BYTES - HEADER_BYTES), 1'b1);
    hp_pages += n;
    r.status = ST_OK;
    r.result_address = 32'(region + HEADER_BYTES);
  endtask

  task automatic predict_free(logic [31:0] addr, output alloc_result_t r);
    int i;
    r.result_address = '0;
    r.status = ST_OK;
    if (addr == 0) begin
      r.status = ST_NULL;
      return;
    end
    for (i = 0; i < hp_count; i++)
      if (longint'(hp_start[i]) + HEADER_BYTES == longint'(addr)) break;
    if (i >= hp_count) begin
      r.status = ST_NOT_FOUND;
      return;
    end
    hp_used[i] = 1'b0;
    if (i > 0 && !hp_used[i-1]) begin
      hp_size[i-1] += hp_size[i] + HEADER_BYTES;
      table_remove(i);
      i--;
    end
    if (i + 1 < hp_count && !hp_used[i+1]) begin
      hp_size[i] += hp_size[i+1] + HEADER_BYTES;
      table_remove(i + 1);
    end
  endtask

  task automatic predict_request(logic op, logic [31:0] size, logic [31:0] addr);
    alloc_result_t r;
    longint fin;
    if (!hp_built) begin
      hp_built = 1'b1;
      fin = longint'(cfg_base) + longint'(cfg_init_pages) * PAGE_BYTES;
      if (!(fin >= ADDR_LIMIT || cfg_init_pages == 0 || cfg_init_pages > cfg_max_pages)) begin
        hp_start[0] = cfg_base;
        hp_size[0] = 32'(longint'(cfg_init_pages) * PAGE_BYTES - HEADER_BYTES);
        hp_used[0] = 1'b0;
        hp_count = 1;
        hp_pages = cfg_init_pages;
      end
    end
    if (op == OP_ALLOC) predict_alloc(size, r);
    else predict_free(addr, r);
    pending_results.push_back(r);
  endtask

  // One request; valid stays high when the next call follows with no gap.
  task automatic send_request(logic op, logic [31:0] size, logic [31:0] addr);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= op;
    req.req_size <= size;
    req.address <= addr;
    do @(posedge clk); while (!req.ready);
    predict_request(op, size, addr);
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Registers are only written once every request in flight has been answered.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_HEAP_BASE:  cfg_base = value;
      REG_INIT_PAGES: cfg_init_pages = value[15:0];
      REG_SPLIT_MIN:  cfg_split_min = value[15:0];
      REG_MAX_PAGES:  cfg_max_pages = value[19:0];
      default: ;
    endcase
  endtask

  // Mostly frees of live blocks and small allocs, with some noise.
  task automatic random_request();
    int pick, i;
    logic [31:0] v;
    if ($urandom_range(0, 99) < 55) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) v = $urandom_range(1, 256);
      else if (pick < 90) v = $urandom_range(257, 9000);
      else if (pick < 95) v = 32'd0;
      else v = $urandom;
      send_request(OP_ALLOC, v, $urandom);
    end else begin
      pick = $urandom_range(0, 99);
      if (hp_count > 0 && pick < 80) begin
        i = $urandom_range(0, hp_count - 1);
        if (pick < 70)
          for (int k = 0; k < hp_count; k++)
            if (hp_used[(i + k) % hp_count]) begin
              i = (i + k) % hp_count;
              break;
            end
        v = hp_start[i] + HEADER_BYTES;
        if (pick >= 77) v = v + 4;
      end else if (pick < 90) v = 32'd0;
      else v = $urandom;
      send_request(OP_FREE, $urandom, v);
    end
  endtask

  task automatic test_basic_requests();
    write_reg(REG_HEAP_BASE, 32'h0040_0000);
    write_reg(REG_INIT_PAGES, 32'd2);
    write_reg(REG_SPLIT_MIN, 32'd16);
    write_reg(REG_MAX_PAGES, 32'd1024);
    send_request(OP_ALLOC, 32'd0, 32'd0);
    send_request(OP_FREE, 32'd0, 32'd0);
    send_request(OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_FREE, 32'd0, 32'h0000_1234);
    send_request(OP_ALLOC, 32'd1, 32'd0);
    send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_request(OP_ALLOC, 32'd8192, 32'd0);
    send_request(OP_ALLOC, 32'd4, 32'd0);
    send_request(OP_FREE, 32'd0, 32'h0040_0010);
    send_request(OP_FREE, 32'd0, 32'h0040_0010);
    send_request(OP_ALLOC, 32'd100, 32'd0);
    send_request(OP_ALLOC, 32'd7, 32'd0);
    drain_results();
  endtask

  // Sizes around the first free block so the split falls on both sides of its limits.
  task automatic test_split_limits();
    logic [31:0] f;
    write_reg(REG_SPLIT_MIN, 32'd0);
    for (int t = 0; t < 4; t++) begin
      f = 0;
      for (int i = 0; i < hp_count; i++)
        if (!hp_used[i] && hp_size[i] > 64) begin
          f = hp_size[i];
          break;
        end
      if (f != 0) send_request(OP_ALLOC, f - 16 + 4 * (t % 2) - 2 * (t / 2), 32'd0);
    end
    write_reg(REG_SPLIT_MIN, 32'd65535);
    send_request(OP_ALLOC, 32'd40, 32'd0);
    write_reg(REG_SPLIT_MIN, 32'd16);
    drain_results();
  endtask

  task automatic test_page_limit();
    write_reg(REG_MAX_PAGES, 32'd1);
    send_request(OP_ALLOC, 32'd70000, 32'd0);
    write_reg(REG_MAX_PAGES, 32'd1048575);
    send_request(OP_ALLOC, 32'd5000, 32'd0);
    send_request(OP_ALLOC, 32'hFFBF_0000, 32'd0);
    drain_results();
  endtask

  // Registers read only at build time are written once the table exists.
  task automatic test_late_writes();
    write_reg(REG_HEAP_BASE, 32'hFFBF_F000);
    write_reg(REG_INIT_PAGES, 32'd65535);
    send_request(OP_ALLOC, 32'd12, 32'd0);
    write_reg(REG_INIT_PAGES, 32'd1);
    send_request(OP_ALLOC, 32'd12, 32'd0);
    drain_results();
  endtask

  task automatic test_full_table();
    write_reg(REG_SPLIT_MIN, 32'd0);
    for (int t = 0; t < 80 && hp_count < MAX_BLOCKS; t++) send_request(OP_ALLOC, 32'd4, 32'd0);
    send_request(OP_ALLOC, 32'd300000, 32'd0);
    send_request(OP_ALLOC, 32'd4, 32'd0);
    drain_results();
  endtask

  task automatic test_random_phases(int count);
    logic [31:0] split_vals[3] = '{32'd16, 32'd0, 32'd65535};
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_SPLIT_MIN, split_vals[p % 3]);
      write_reg(REG_MAX_PAGES, (p == 4) ? 32'd1048575 : 32'd2048);
      repeat (count / 6) random_request();
      drain_results();
    end
  endtask

  task automatic test_output_stall();
    long_hold = 1'b1;
    repeat (30) random_request();
    drain_results();
  endtask

  task automatic test_no_gaps(int count);
    no_idle = 1'b1;
    repeat (count) random_request();
    drain_results();
  endtask

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        rsp.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
        rsp.ready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result addr=%h status=%0d", $time,
                 rsp.result_address, rsp.status);
        errors++;
      end else begin
        alloc_result_t e;
        e = pending_results.pop_front();
        if (rsp.result_address !== e.result_address) begin
          $display("%0t: result_address expected %h actual %h", $time,
                   e.result_address, rsp.result_address);
          errors++;
        end
        if (rsp.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, rsp.status);
          errors++;
        end
      end
    end
  end

  initial begin
    hp_count = 0;
    hp_pages = 0;
    hp_built = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_requests();
    test_split_limits();
    test_page_limit();
    test_late_writes();
    test_full_table();
    test_random_phases(1440);
    test_output_stall();
    test_no_gaps(150);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

/* files.f */
sv/ffha_pkg.sv
sv/ffha_if.sv
sv/ffha_ram.sv
sv/first_fit_heap_allocator.sv
sim/first_fit_heap_allocator_tb.sv
